### src/cld_pkg.sv
package cld_pkg;

	localparam int HdrLen = 16;

	localparam logic [7:0] ChrCr    = 8'h0d;
	localparam logic [7:0] ChrLf    = 8'h0a;
	localparam logic [7:0] ChrSpace = 8'h20;
	localparam logic [7:0] ChrZero  = 8'h30;
	localparam logic [7:0] ChrNine  = 8'h39;

	// "Content-Length: " one character per position
	function automatic logic [7:0] hdr_char(input logic [3:0] pos);
		logic [7:0] c;
		unique case (pos)
			4'd0:    c = 8'h43; // C
			4'd1:    c = 8'h6f; // o
			4'd2:    c = 8'h6e; // n
			4'd3:    c = 8'h74; // t
			4'd4:    c = 8'h65; // e
			4'd5:    c = 8'h6e; // n
			4'd6:    c = 8'h74; // t
			4'd7:    c = 8'h2d; // -
			4'd8:    c = 8'h4c; // L
			4'd9:    c = 8'h65; // e
			4'd10:   c = 8'h6e; // n
			4'd11:   c = 8'h67; // g
			4'd12:   c = 8'h74; // t
			4'd13:   c = 8'h68; // h
			4'd14:   c = 8'h3a; // :
			default: c = 8'h20; // space
		endcase
		return c;
	endfunction

	typedef struct packed {
		logic [7:0] body_byte;
		logic       last_of_message;
		logic       length_clipped;
	} cld_result_t;

endpackage

### src/content_length_deframer.sv
// Extracts message bodies from a byte stream framed by "Content-Length: N"
// header lines ending in CR LF; a bare CR LF line starts the body, whose N
// bytes leave on the master side with tlast on the final one and tuser set
// when N exceeded MAX_BODY and was held at MAX_BODY. Header bytes and empty
// bodies produce no output beat. One byte is taken every clock cycle: the
// header matcher, decimal accumulate and body counter all update in a single
// pass between the input register and the output register. A stalled output
// holds off input only when both registers are full.
module content_length_deframer #(
	parameter int MAX_BODY = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] body_byte
	output logic       m_tlast,   // last_of_message
	output logic       m_tuser    // [0] length_clipped
);

	logic                 advance;
	logic                 valid_s1;
	logic [7:0]           data_s1;
	logic                 emit;
	cld_pkg::cld_result_t result;

	cld_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	cld_parser #(
		.MAX_BODY (MAX_BODY)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.data_s1 (data_s1),
		.emit    (emit),
		.result  (result)
	);

	cld_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.emit     (emit),
		.result   (result),
		.advance  (advance),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

### src/cld_in_reg.sv
module cld_in_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] data_s1
);

	logic valid_q;

	assign s_tready = !valid_q || advance;
	assign valid_s1 = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s_tready) begin
			valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
		end
	end

endmodule

### src/cld_parser.sv
module cld_parser #(
	parameter int MAX_BODY = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic [7:0]           data_s1,
	output logic                 emit,
	output cld_pkg::cld_result_t result
);

	localparam int LW = $clog2(MAX_BODY + 1);
	localparam int PW = LW + 4;

	typedef enum logic [1:0] {
		PH_SEARCH,
		PH_SPACES,
		PH_DIGITS,
		PH_DONE
	} phase_t;

	logic          in_body_q, in_body_d;
	logic [3:0]    pos_q, pos_d;
	phase_t        phase_q, phase_d;
	logic [LW-1:0] decl_q, decl_d;
	logic [1:0]    line_cnt_q, line_cnt_d;
	logic          prev_cr_q, prev_cr_d;
	logic [LW-1:0] remain_q, remain_d;
	logic          clip_q, clip_d;

	logic          is_digit;
	logic [PW-1:0] prod;
	logic          last;

	assign is_digit = (data_s1 >= cld_pkg::ChrZero) && (data_s1 <= cld_pkg::ChrNine);
	assign prod = {1'b0, decl_q, 3'b000} + {3'b000, decl_q, 1'b0}
		+ PW'(data_s1 - cld_pkg::ChrZero);
	assign last = (remain_q <= LW'(1));

	always_comb begin
		in_body_d  = in_body_q;
		pos_d      = pos_q;
		phase_d    = phase_q;
		decl_d     = decl_q;
		line_cnt_d = line_cnt_q;
		prev_cr_d  = prev_cr_q;
		remain_d   = remain_q;
		clip_d     = clip_q;
		emit       = 1'b0;

		if (in_body_q) begin
			emit = 1'b1;
			if (last) begin
				in_body_d  = 1'b0;
				remain_d   = '0;
				decl_d     = '0;
				clip_d     = 1'b0;
				pos_d      = '0;
				phase_d    = PH_SEARCH;
				line_cnt_d = '0;
				prev_cr_d  = 1'b0;
			end else begin
				remain_d = remain_q - LW'(1);
			end
		end else if (data_s1 == cld_pkg::ChrLf && prev_cr_q) begin
			// end of line; a line holding only CR starts the body if a nonzero length was declared
			pos_d      = '0;
			phase_d    = PH_SEARCH;
			line_cnt_d = '0;
			prev_cr_d  = 1'b0;
			if (line_cnt_q == 2'd1 && phase_q == PH_SEARCH && decl_q != '0) begin
				in_body_d = 1'b1;
				remain_d  = decl_q;
			end
		end else begin
			unique case (phase_q)
				PH_SEARCH: begin
					if (data_s1 == cld_pkg::hdr_char(pos_q)) begin
						if (pos_q == 4'(cld_pkg::HdrLen - 1)) begin
							pos_d   = '0;
							phase_d = PH_SPACES;
							decl_d  = '0;
							clip_d  = 1'b0;
						end else begin
							pos_d = pos_q + 4'd1;
						end
					end else begin
						pos_d = (data_s1 == cld_pkg::hdr_char(4'd0)) ? 4'd1 : 4'd0;
					end
				end
				PH_SPACES, PH_DIGITS: begin
					if (is_digit) begin
						phase_d = PH_DIGITS;
						if (prod > PW'(MAX_BODY)) begin
							decl_d = LW'(MAX_BODY);
							clip_d = 1'b1;
						end else begin
							decl_d = prod[LW-1:0];
						end
					end else if (!(phase_q == PH_SPACES && data_s1 == cld_pkg::ChrSpace)) begin
						phase_d = PH_DONE;
					end
				end
				default: begin
				end
			endcase
			if (line_cnt_q != 2'd3) begin
				line_cnt_d = line_cnt_q + 2'd1;
			end
			prev_cr_d = (data_s1 == cld_pkg::ChrCr);
		end
	end

	always_comb begin
		result.body_byte       = data_s1;
		result.last_of_message = last;
		result.length_clipped  = clip_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_body_q  <= 1'b0;
			pos_q      <= '0;
			phase_q    <= PH_SEARCH;
			decl_q     <= '0;
			line_cnt_q <= '0;
			prev_cr_q  <= 1'b0;
			remain_q   <= '0;
			clip_q     <= 1'b0;
		end else if (advance) begin
			in_body_q  <= in_body_d;
			pos_q      <= pos_d;
			phase_q    <= phase_d;
			decl_q     <= decl_d;
			line_cnt_q <= line_cnt_d;
			prev_cr_q  <= prev_cr_d;
			remain_q   <= remain_d;
			clip_q     <= clip_d;
		end
	end

endmodule

### src/cld_out_reg.sv
module cld_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_s1,
	input  logic                 emit,
	input  cld_pkg::cld_result_t result,
	output logic                 advance,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,  // [7:0] body_byte
	output logic                 m_tlast,
	output logic                 m_tuser   // [0] length_clipped
);

	logic valid_q;

	assign m_tvalid = valid_q;
	assign advance  = valid_s1 && (!valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= emit;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			m_tdata <= result.body_byte;
			m_tlast <= result.last_of_message;
			m_tuser <= result.length_clipped;
		end
	end

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int BodyMax = 64;
	localparam int CalmTail = 150;
	localparam int LongHold = 300;
	localparam int PrintCap = 30;
	localparam string HdrText = "Content-Length: ";

	typedef enum logic [1:0] {NUM_SEARCH, NUM_SPACES, NUM_DIGITS, NUM_DONE} num_phase_t;
	// ROW_QUIET: no beat may come from these bytes; ROW_BEAT: beat typed in the row
	typedef enum logic [1:0] {ROW_PREDICT, ROW_QUIET, ROW_BEAT} row_kind_t;

	typedef struct {
		logic [7:0]           data;
		row_kind_t            kind;
		cld_pkg::cld_result_t beat;
		bit                   drain;
		bit                   hold;
	} feed_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;  // [7:0] data_byte
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;          // [7:0] body_byte
	logic       m_tlast;          // last_of_message
	logic       m_tuser;          // [0] length_clipped

	feed_t                feed_q[$];
	cld_pkg::cld_result_t pending_beats[$];
	bit                   calm = 1'b0;
	bit                   hold_req = 1'b0;
	int                   errors = 0;
	int                   n_bytes = 0;
	int                   n_beats = 0;
	int                   n_msgs = 0;
	int                   n_clip = 0;

	// framing tracker state
	logic        rx_in_body;
	logic [4:0]  hdr_pos;
	num_phase_t  num_state;
	logic [12:0] len_decl;
	logic [1:0]  line_len;
	logic        cr_seen;
	logic [12:0] body_left;
	logic        len_clip;

	content_length_deframer #(
		.MAX_BODY(BodyMax)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	always #6 clk = ~clk;

	initial begin : watchdog
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

	task automatic report_mismatch(input string what);
		errors++;
		if (errors <= PrintCap) $display("mismatch at %0t ns: %s", $time, what);
	endtask

	task automatic clear_line();
		hdr_pos = '0;
		num_state = NUM_SEARCH;
		line_len = '0;
		cr_seen = 1'b0;
	endtask

	// one stream byte through the framing rules; yields the body beat it causes
	task automatic track_byte(input logic [7:0] b, output bit has_beat,
			output cld_pkg::cld_result_t beat);
		int unsigned acc;
		bit bare;
		has_beat = 1'b0;
		beat = '0;
		if (rx_in_body) begin
			has_beat = 1'b1;
			beat.body_byte = b;
			beat.last_of_message = (body_left <= 13'd1);
			beat.length_clipped = len_clip;
			if (beat.last_of_message) begin
				rx_in_body = 1'b0;
				body_left = '0;
				len_decl = '0;
				len_clip = 1'b0;
				clear_line();
			end else begin
				body_left = body_left - 13'd1;
			end
		end else if (b == cld_pkg::ChrLf && cr_seen) begin
			bare = (line_len == 2'd1) && (num_state == NUM_SEARCH);
			clear_line();
			if (bare && len_decl != 0) begin
				rx_in_body = 1'b1;
				body_left = len_decl;
			end
		end else begin
			if (num_state == NUM_SEARCH) begin
				// header text has no self-overlap past its first letter
				if (hdr_pos < cld_pkg::HdrLen && b == HdrText[hdr_pos])
					hdr_pos = hdr_pos + 5'd1;
				else hdr_pos = (b == HdrText[0]) ? 5'd1 : 5'd0;
				if (hdr_pos >= cld_pkg::HdrLen) begin
					hdr_pos = '0;
					num_state = NUM_SPACES;
					len_decl = '0;
					len_clip = 1'b0;
				end
			end else if (num_state == NUM_SPACES || num_state == NUM_DIGITS) begin
				if (b >= cld_pkg::ChrZero && b <= cld_pkg::ChrNine) begin
					acc = len_decl * 10 + (b - cld_pkg::ChrZero);
					if (acc > BodyMax) begin
						acc = BodyMax;
						len_clip = 1'b1;
					end
					len_decl = acc[12:0];
					num_state = NUM_DIGITS;
				end else if (!(num_state == NUM_SPACES && b == cld_pkg::ChrSpace)) begin
					num_state = NUM_DONE;
				end
			end
			if (line_len < 2'd3) line_len = line_len + 2'd1;
			cr_seen = (b == cld_pkg::ChrCr);
		end
	endtask

	task automatic add_byte(input logic [7:0] b, input row_kind_t k,
			input cld_pkg::cld_result_t r);
		feed_t f;
		f.data = b;
		f.kind = k;
		f.beat = r;
		f.drain = 1'b0;
		f.hold = 1'b0;
		feed_q.push_back(f);
	endtask

	task automatic add_text(input string s, input row_kind_t k);
		for (int i = 0; i < s.len(); i++) add_byte(s[i], k, '0);
	endtask

	task automatic add_beat(input logic [7:0] b, input logic l, input logic c);
		cld_pkg::cld_result_t r;
		r.body_byte = b;
		r.last_of_message = l;
		r.length_clipped = c;
		add_byte(b, ROW_BEAT, r);
	endtask

	function automatic string junk_line();
		string s;
		case ($urandom_range(0, 5))
			0: s = "Content-Len";
			1: s = "Content-Length:7";
			2: s = "a\nb";
			3: s = "c\rd";
			default: begin
				s = "";
				repeat ($urandom_range(1, 10)) s = {s, $sformatf("%c", $urandom_range(32, 126))};
			end
		endcase
		return {s, "\r\n"};
	endfunction

	task automatic gen_message(input int body_len, input string len_txt, input bit hold_it);
		string line;
		int first;
		repeat ($urandom_range(0, 2)) add_text(junk_line(), ROW_PREDICT);
		// an earlier header line that the real one overrides
		if ($urandom_range(0, 7) == 0)
			add_text($sformatf("Content-Length: %0d\r\n", $urandom_range(0, 99999)), ROW_PREDICT);
		case ($urandom_range(0, 3))
			0: line = "X-";
			1: line = "Cont";
			default: line = "";
		endcase
		line = {line, "Content-Length: "};
		repeat ($urandom_range(0, 2)) line = {line, " "};
		line = {line, len_txt};
		case ($urandom_range(0, 5))
			0: line = {line, ";x"};
			1: line = {line, " Content-Length: 9"};
			default: ;
		endcase
		add_text({line, "\r\n"}, ROW_PREDICT);
		if ($urandom_range(0, 4) == 0) add_text(junk_line(), ROW_PREDICT);
		add_text("\r\n", ROW_PREDICT);
		first = feed_q.size();
		repeat (body_len) add_byte(8'($urandom), ROW_PREDICT, '0);
		if (hold_it && body_len > 0) feed_q[first].hold = 1'b1;
	endtask

	always @(posedge clk) begin : check_beats
		cld_pkg::cld_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_beats.size() == 0) begin
				report_mismatch($sformatf("body beat %02h with nothing pending", m_tdata));
			end else begin
				want = pending_beats.pop_front();
				if (m_tdata !== want.body_byte)
					report_mismatch($sformatf("tdata %02h, want %02h", m_tdata, want.body_byte));
				if (m_tlast !== want.last_of_message)
					report_mismatch($sformatf("tlast %b, want %b", m_tlast, want.last_of_message));
				if (m_tuser !== want.length_clipped)
					report_mismatch($sformatf("tuser %b, want %b", m_tuser, want.length_clipped));
				n_beats++;
				if (want.last_of_message) n_msgs++;
				if (want.length_clipped) n_clip++;
			end
		end
	end

	initial begin : sink
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (LongHold) @(posedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat (calm ? 20 : $urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	initial begin : main
		feed_t it;
		bit got;
		cld_pkg::cld_result_t beat;
		string txt;
		int calm_from;
		int filler;
		int start_idx;
		int msg_no;
		int len;
		int w;

		// directed framing cases
		add_text("\r\n", ROW_QUIET);
		add_text("Content-Length: 2\r\n\r\n", ROW_QUIET);
		add_beat(cld_pkg::ChrCr, 1'b0, 1'b0);
		add_beat(cld_pkg::ChrLf, 1'b1, 1'b0);
		add_text("ContContent-Length:  -7\r\n\r\n", ROW_QUIET);
		add_text("Content-Length: 1 Content-Length: 9\r\n\n\r\n\r\n", ROW_QUIET);
		add_beat(8'hff, 1'b1, 1'b0);
		add_text("Content-Length: 0003x\r\n\r\n", ROW_QUIET);
		add_beat(8'h00, 1'b0, 1'b0);
		add_beat(8'h80, 1'b0, 1'b0);
		add_beat(8'h7f, 1'b1, 1'b0);

		// random messages, noise and a couple of full-size bodies
		filler = 0;
		msg_no = 0;
		while (filler < 700) begin
			start_idx = feed_q.size();
			if (msg_no == 6) begin
				gen_message(48, "48", 1'b1);
			end else if (msg_no == 10) begin
				gen_message(BodyMax, $sformatf("%0d", BodyMax), 1'b0);
			end else if (msg_no == 20) begin
				gen_message(BodyMax, "70000", 1'b0);
			end else begin
				case ($urandom_range(0, 15))
					0: repeat ($urandom_range(1, 8)) add_byte(8'($urandom), ROW_PREDICT, '0);
					1: add_text("\r\n", ROW_PREDICT);
					2: gen_message(0, ($urandom_range(0, 1) ? "-5" : "+5"), 1'b0);
					3: gen_message(0, "0", 1'b0);
					default: begin
						len = ($urandom_range(0, 5) == 0) ? $urandom_range(41, BodyMax)
							: $urandom_range(1, 40);
						txt = $sformatf("%0d", len);
						if ($urandom_range(0, 3) == 0) txt = {"00", txt};
						gen_message(len, txt, 1'b0);
					end
				endcase
			end
			filler += feed_q.size() - start_idx;
			if (msg_no % 16 == 0) feed_q[start_idx].drain = 1'b1;
			msg_no++;
		end
		calm_from = feed_q.size() - CalmTail;

		rx_in_body = 1'b0;
		len_decl = '0;
		body_left = '0;
		len_clip = 1'b0;
		clear_line();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < feed_q.size(); i++) begin
			it = feed_q[i];
			if (i >= calm_from) calm = 1'b1;
			if (it.hold) hold_req = 1'b1;
			if (it.drain && !calm) begin
				s_tvalid <= 1'b0;
				while (pending_beats.size() != 0) @(posedge clk);
				repeat (4) @(posedge clk);
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata <= it.data;
			do @(posedge clk); while (!s_tready);
			n_bytes++;
			track_byte(it.data, got, beat);
			if (it.kind == ROW_BEAT) pending_beats.push_back(it.beat);
			else if (it.kind == ROW_PREDICT && got) pending_beats.push_back(beat);
		end
		s_tvalid <= 1'b0;

		for (w = 0; w < 2000 && pending_beats.size() != 0; w++) @(posedge clk);
		if (pending_beats.size() != 0)
			report_mismatch($sformatf("%0d body beats never came", pending_beats.size()));
		repeat (8) @(posedge clk);

		$display("run covered %0d stream bytes, %0d body beats in %0d messages, %0d clipped",
			n_bytes, n_beats, n_msgs, n_clip);
		$display("stimulus: directed cases, noise, broken headers, full bodies, stalls, %0d cycle hold",
			LongHold);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
